/* hw/rtl/rebq_pkg.sv */
`timescale 1ns / 1ps

package rebq_pkg;

   // accumulator width, signed
   localparam int ACC_WIDTH = 16;
   localparam int DIFF_WIDTH = 15;
   // compare width for saturating the halved accumulator
   localparam int CMP_WIDTH = 33;

   // reset values of the configuration registers
   localparam logic        ENABLE_RESET   = 1'b1;
   localparam logic [7:0]  DEBOUNCE_RESET = 8'd6;
   localparam logic [15:0] LONG_RESET     = 16'd160;
   localparam logic [7:0]  SETTLE_RESET   = 8'd255;

   // request codes
   localparam logic [1:0] REQ_ENCODER = 2'd0;
   localparam logic [1:0] REQ_TICK    = 2'd1;
   localparam logic [1:0] REQ_READ    = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_ENABLE   = 2'd0;
   localparam logic [1:0] CSR_DEBOUNCE = 2'd1;
   localparam logic [1:0] CSR_LONG     = 2'd2;

   // tone event codes
   localparam logic [2:0] TONE_NONE    = 3'd0;
   localparam logic [2:0] TONE_PRESS   = 3'd1;
   localparam logic [2:0] TONE_RELEASE = 3'd2;
   localparam logic [2:0] TONE_LONG    = 3'd3;
   localparam logic [2:0] TONE_READ    = 3'd4;

   typedef struct packed {
      logic [1:0] req_type;
      logic       pin_a;
      logic       pin_b;
      logic       push_req;
   } req_payload_type;

   typedef struct packed {
      logic signed [DIFF_WIDTH-1:0] diff_steps;
      logic                         click;
      logic                         long_click;
      logic                         pressed;
      logic                         activity;
      logic [2:0]                   tone_event;
   } rsp_payload_type;

   // button state seen by the rest of the block
   typedef struct packed {
      logic blocked;
      logic stable_level;
      logic click_flag;
      logic long_flag;
   } btn_status_type;

   // what one tick item causes, with the debounced level after it
   typedef struct packed {
      logic       activity;
      logic       level;
      logic [2:0] tone;
   } btn_event_type;

   // what one encoder or read item causes
   typedef struct packed {
      logic                         activity;
      logic                         nonzero;
      logic signed [DIFF_WIDTH-1:0] diff;
   } enc_result_type;

endpackage

/* hw/rtl/rebq_button.sv */
`timescale 1ns / 1ps

module rebq_button import rebq_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           tick,
   input  logic           clear,
   input  logic           push,
   input  logic [7:0]     debounce_count,
   input  logic [15:0]    long_count,
   output btn_status_type status,
   output btn_event_type  evt
);

   logic        filter_ff, filter_in;
   logic        stable_ff, stable_in;
   logic [7:0]  settle_ff, settle_in;
   logic [15:0] hold_ff, hold_in;
   logic        long_rep_ff, long_rep_in;
   logic        blocked_ff, blocked_in;
   logic        click_ff, click_in;
   logic        long_ff, long_in;

   // debounce, hold timing and press / release detection
   always_comb begin
      filter_in   = filter_ff;
      stable_in   = stable_ff;
      settle_in   = settle_ff;
      hold_in     = hold_ff;
      long_rep_in = long_rep_ff;
      blocked_in  = blocked_ff;
      click_in    = click_ff;
      long_in     = long_ff;
      evt         = '{activity: 1'b0, level: stable_ff, tone: TONE_NONE};
      if (push != filter_ff) begin
         filter_in = push;
         settle_in = '0;
      end else if (settle_ff < debounce_count) begin
         settle_in = settle_ff + 8'd1;
      end else if (push == stable_ff) begin
         if (push && !long_rep_ff) begin
            if (hold_ff < long_count) begin
               hold_in = hold_ff + 16'd1;
            end else begin
               long_in     = 1'b1;
               long_rep_in = 1'b1;
               evt         = '{activity: 1'b1, level: stable_ff, tone: TONE_LONG};
            end
         end
      end else begin
         if (push) begin
            blocked_in  = 1'b1;
            long_rep_in = 1'b0;
            evt.tone    = TONE_PRESS;
         end else begin
            blocked_in = 1'b0;
            if (!long_rep_ff) begin
               click_in = 1'b1;
            end
            evt.tone = TONE_RELEASE;
         end
         hold_in      = '0;
         stable_in    = push;
         evt.level    = push;
         evt.activity = 1'b1;
      end
   end

   // update on a tick, drop the flags on a read
   always_ff @(posedge clock) begin
      if (reset) begin
         filter_ff   <= 1'b0;
         stable_ff   <= 1'b0;
         settle_ff   <= SETTLE_RESET;
         hold_ff     <= '0;
         long_rep_ff <= 1'b0;
         blocked_ff  <= 1'b0;
         click_ff    <= 1'b0;
         long_ff     <= 1'b0;
      end else if (tick) begin
         filter_ff   <= filter_in;
         stable_ff   <= stable_in;
         settle_ff   <= settle_in;
         hold_ff     <= hold_in;
         long_rep_ff <= long_rep_in;
         blocked_ff  <= blocked_in;
         click_ff    <= click_in;
         long_ff     <= long_in;
      end else if (clear) begin
         click_ff <= 1'b0;
         long_ff  <= 1'b0;
      end
   end

   assign status = '{blocked: blocked_ff, stable_level: stable_ff,
                     click_flag: click_ff, long_flag: long_ff};

endmodule

/* hw/rtl/rebq_encoder.sv */
`timescale 1ns / 1ps

module rebq_encoder import rebq_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           sample,
   input  logic           read,
   input  logic           pin_a,
   input  logic           pin_b,
   input  logic           enable,
   input  logic           blocked,
   output enc_result_type result
);

   localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
   localparam logic signed [CMP_WIDTH-1:0] DIFF_MAX =
      CMP_WIDTH'((64'sd1 <<< (DIFF_WIDTH - 1)) - 64'sd1);
   localparam logic signed [CMP_WIDTH-1:0] DIFF_MIN =
      CMP_WIDTH'(-(64'sd1 <<< (DIFF_WIDTH - 1)));

   logic                        a_last_ff, a_last_in;
   logic                        b_last_ff, b_last_in;
   logic signed [ACC_WIDTH-1:0] acc_ff, acc_in;
   logic signed [ACC_WIDTH-1:0] half;
   logic signed [CMP_WIDTH-1:0] half_wide;
   logic                        step;

   // halve toward zero: round negatives up before the shift
   assign half      = $signed(acc_ff + ACC_WIDTH'(acc_ff[ACC_WIDTH-1])) >>> 1;
   assign half_wide = CMP_WIDTH'(half);

   always_comb begin
      a_last_in = a_last_ff;
      b_last_in = b_last_ff;
      acc_in    = acc_ff;
      step      = 1'b0;
      if (sample) begin
         if (enable && !blocked && (pin_a != a_last_ff)) begin
            a_last_in = pin_a;
            if (pin_b != b_last_ff) begin
               b_last_in = pin_b;
               step      = 1'b1;
               // saturate at the accumulator limits
               if (pin_a == pin_b) begin
                  if (acc_ff != ACC_MAX) begin
                     acc_in = acc_ff + ACC_WIDTH'(1);
                  end
               end else if (acc_ff != ACC_MIN) begin
                  acc_in = acc_ff - ACC_WIDTH'(1);
               end
            end
         end
      end else if (read && (half != '0)) begin
         acc_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_last_ff <= 1'b0;
         b_last_ff <= 1'b0;
         acc_ff    <= '0;
      end else begin
         a_last_ff <= a_last_in;
         b_last_ff <= b_last_in;
         acc_ff    <= acc_in;
      end
   end

   // clamp the halved value to the output range
   always_comb begin
      result.activity = step;
      result.nonzero  = (half != '0);
      if (half_wide > DIFF_MAX) begin
         result.diff = DIFF_MAX[DIFF_WIDTH-1:0];
      end else if (half_wide < DIFF_MIN) begin
         result.diff = DIFF_MIN[DIFF_WIDTH-1:0];
      end else begin
         result.diff = half_wide[DIFF_WIDTH-1:0];
      end
   end

endmodule

/* hw/rtl/rotary_encoder_button_qualifier_core.sv */
`timescale 1ns / 1ps
// Rotary encoder and push button qualifier.
// Request channel (req_valid / req_stall / req_payload) takes one item per
// cycle while req_stall is low: an encoder pin sample, a button tick, or a
// read that returns the halved step count and click flags, clearing any nonzero.
// Response channel (rsp_valid / rsp_stall / rsp_payload) gives exactly one
// item per request, in order.
// The request is held in the input register and then moves to the result
// register, where rsp_valid rises. Throughput: one item per cycle while the
// receiver does not stall, set by the single pass from the input register to
// the result register in which all state is updated.
// When the receiver stalls, the result register holds; the input register
// keeps accepting until it is full, then req_stall rises.
// Configuration (csr_valid / csr_ready / csr_index / csr_wdata) is always
// ready: index 0 enable, 1 debounce count, 2 long press count. Write it only
// while no item is in flight.
// Synchronous reset empties both registers, clears the button and encoder
// state and restores the configuration defaults.
module rotary_encoder_button_qualifier_core import rebq_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [1:0]      csr_index,
   input  logic [15:0]     csr_wdata
);

   logic            enable_ff;
   logic [7:0]      debounce_ff;
   logic [15:0]     long_ff;
   logic            in_valid_ff, in_valid_in;
   req_payload_type in_item_ff;
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_item_ff, out_item_in;
   logic            advance;
   logic            accept;
   logic            is_read;
   btn_status_type  btn_status;
   btn_event_type   btn_evt;
   enc_result_type  enc_result;

   // configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= ENABLE_RESET;
         debounce_ff <= DEBOUNCE_RESET;
         long_ff     <= LONG_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ENABLE:   enable_ff   <= csr_wdata[0];
            CSR_DEBOUNCE: debounce_ff <= csr_wdata[7:0];
            CSR_LONG:     long_ff     <= csr_wdata;
            default:      ;
         endcase
      end
   end

   // move the item on when the result register is free or being taken
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign is_read   = (in_item_ff.req_type == REQ_READ);

   rebq_button u_button (
      .clock          (clock),
      .reset          (reset),
      .tick           (advance && (in_item_ff.req_type == REQ_TICK)),
      .clear          (advance && is_read),
      .push           (in_item_ff.push_req),
      .debounce_count (debounce_ff),
      .long_count     (long_ff),
      .status         (btn_status),
      .evt            (btn_evt)
   );

   rebq_encoder u_encoder (
      .clock   (clock),
      .reset   (reset),
      .sample  (advance && (in_item_ff.req_type == REQ_ENCODER)),
      .read    (advance && is_read),
      .pin_a   (in_item_ff.pin_a),
      .pin_b   (in_item_ff.pin_b),
      .enable  (enable_ff),
      .blocked (btn_status.blocked),
      .result  (enc_result)
   );

   // build the result item
   always_comb begin
      out_item_in            = '0;
      out_item_in.pressed    = enable_ff && btn_status.stable_level;
      case (in_item_ff.req_type)
         REQ_ENCODER: begin
            out_item_in.activity = enc_result.activity;
         end
         REQ_TICK: begin
            // report the level as it stands after this tick
            out_item_in.pressed    = enable_ff && btn_evt.level;
            out_item_in.activity   = btn_evt.activity;
            out_item_in.tone_event = btn_evt.tone;
         end
         REQ_READ: begin
            out_item_in.diff_steps = enc_result.diff;
            out_item_in.click      = btn_status.click_flag;
            out_item_in.long_click = btn_status.long_flag;
            out_item_in.tone_event = enc_result.nonzero ? TONE_READ : TONE_NONE;
         end
         default: ;
      endcase
   end

   // input and result register control
   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = advance || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_payload;
      end
      if (advance) begin
         out_item_ff <= out_item_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_item_ff;

`ifndef SYNTHESIS
   // a full input register only waits on a stalled result
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input held while result register free");

   // a read tone only comes with a nonzero step count
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.tone_event == TONE_READ)) |->
      (rsp_payload.diff_steps != '0))
      else $error("read tone without steps");

   // button tones always pulse activity
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ((rsp_payload.tone_event == TONE_PRESS) ||
                     (rsp_payload.tone_event == TONE_RELEASE) ||
                     (rsp_payload.tone_event == TONE_LONG))) |->
      rsp_payload.activity)
      else $error("button tone without activity");

   // click flags appear only on a read, which has no activity
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.click || rsp_payload.long_click)) |->
      !rsp_payload.activity)
      else $error("click flag outside a read");
`endif

endmodule
